FILE: hdl/ntw_pkg.sv
// ----------------------------------------------------------------------------
// ntw_pkg: shared types and constants for number_to_word_tokens
// Holds field widths, word codes and the status struct that the
// conversion unit hands to the word sequencer.
// ----------------------------------------------------------------------------
package ntw_pkg;

    localparam int NUM_W  = 31;                   // width of the input number
    localparam int WORD_W = 5;                    // width of one word code
    localparam int DIGITS = 10;                   // decimal digits of a 31-bit value
    localparam int BCD_W  = 4 * DIGITS;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    typedef logic [NUM_W-1:0]  number_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BCD_W-1:0]  bcd_t;
    typedef logic [3:0]        digit_t;

    // Word codes.
    localparam word_t WORD_ZERO       = 5'd0;
    localparam word_t WORD_TEEN_BASE  = 5'd10;    // Ten plus the ones digit
    localparam word_t WORD_TENS_BASE  = 5'd18;    // Twenty is this plus two
    localparam word_t WORD_HUNDRED    = 5'd28;
    localparam word_t WORD_SCALE_BASE = 5'd28;    // Thousand is this plus one

    // Status of the binary to BCD conversion unit.
    typedef struct packed {
        logic busy;
        logic done;
    } bcd_stat_t;

endpackage

FILE: hdl/ntw_if.sv
// ----------------------------------------------------------------------------
// ntw_if: channel interfaces for number_to_word_tokens
// One interface for the input number and one for the emitted word codes,
// each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ntw_num_if;
    logic             valid;
    logic             ready;
    ntw_pkg::number_t number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface ntw_word_if;
    logic           valid;
    logic           ready;
    ntw_pkg::word_t word_code;
    logic           last_word;

    modport source (output valid, output word_code, output last_word, input ready);
    modport sink   (input valid, input word_code, input last_word, output ready);
endinterface

FILE: hdl/ntw_bcd.sv
// ----------------------------------------------------------------------------
// ntw_bcd: iterative binary to BCD converter
// A shift-and-add-three unit that moves one bit of the number into the
// decimal digit register per cycle.
// ----------------------------------------------------------------------------
module ntw_bcd (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  ntw_pkg::number_t      value,
    output ntw_pkg::bcd_stat_t    stat,
    output ntw_pkg::bcd_t         digits
);

    ntw_pkg::bcd_t                  digits_reg, digits_next;
    ntw_pkg::number_t               bin_reg, bin_next;
    logic [ntw_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    ntw_pkg::bcd_t                  adj;

    // Every digit of five or more gets three added before the shift, so
    // that the shift carries correctly into the next decimal digit.
    always_comb
    begin
        adj = digits_reg;
        for (int i = 0; i < ntw_pkg::DIGITS; i++)
        begin
            if (digits_reg[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = digits_reg[i*4 +: 4] + 4'd3;
            end
        end
    end

    always_comb
    begin
        digits_next = digits_reg;
        bin_next    = bin_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = busy_reg && (cnt_reg == ntw_pkg::CNT_W'(1));
        if (start)
        begin
            digits_next = '0;
            bin_next    = value;
            cnt_next    = ntw_pkg::CNT_W'(ntw_pkg::NUM_W);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            digits_next = {adj[ntw_pkg::BCD_W-2:0], bin_reg[ntw_pkg::NUM_W-1]};
            bin_next    = {bin_reg[ntw_pkg::NUM_W-2:0], 1'b0};
            cnt_next    = cnt_reg - ntw_pkg::CNT_W'(1);
            busy_next   = (cnt_reg != ntw_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        bin_reg    <= bin_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign digits    = digits_reg;

`ifndef SYNTHESIS
    a_busy_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("conversion busy with an empty bit count");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("conversion did not start");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("conversion done without a finished run");
`endif

endmodule

FILE: hdl/ntw_words.sv
// ----------------------------------------------------------------------------
// ntw_words: word sequencer and output register
// Walks the base-1000 groups of the decimal digits, most significant
// first, and emits the word codes into the output register, advancing only while that register can take a word.
// ----------------------------------------------------------------------------
module ntw_words (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  ntw_pkg::bcd_stat_t    stat,
    input  ntw_pkg::bcd_t         digits,
    output logic                  idle,
    ntw_word_if.source            words
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CONV  = 8'b0000_0010,
        S_ZERO  = 8'b0000_0100,
        S_HDIG  = 8'b0000_1000,
        S_HWORD = 8'b0001_0000,
        S_REST  = 8'b0010_0000,
        S_ONES  = 8'b0100_0000,
        S_SCALE = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      grp_reg, grp_next;
    logic            valid_reg, valid_next;
    ntw_pkg::word_t  word_reg, word_next;
    logic            last_reg, last_next;

    logic            load;
    logic            emit;
    ntw_pkg::word_t  code;
    logic            last;
    ntw_pkg::digit_t hun, ten, one;
    logic            lower_zero;
    logic            grp_zero;
    logic            rest_zero;
    logic            low_grp;

    // Digits of the current group; the top group holds the billions digit.
    always_comb
    begin
        case (grp_reg)
            2'd3:
            begin
                hun        = '0;
                ten        = '0;
                one        = digits[39:36];
                lower_zero = (digits[35:0] == '0);
            end
            2'd2:
            begin
                hun        = digits[35:32];
                ten        = digits[31:28];
                one        = digits[27:24];
                lower_zero = (digits[23:0] == '0);
            end
            2'd1:
            begin
                hun        = digits[23:20];
                ten        = digits[19:16];
                one        = digits[15:12];
                lower_zero = (digits[11:0] == '0);
            end
            default:
            begin
                hun        = digits[11:8];
                ten        = digits[7:4];
                one        = digits[3:0];
                lower_zero = 1'b1;
            end
        endcase
    end

    assign rest_zero = (ten == '0) && (one == '0);
    assign grp_zero  = (hun == '0) && rest_zero;
    assign low_grp   = (grp_reg == 2'd0);
    assign load      = !valid_reg || words.ready;

    always_comb
    begin
        state_next = state_reg;
        grp_next   = grp_reg;
        emit       = 1'b0;
        code       = ntw_pkg::WORD_ZERO;
        last       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (stat.done)
                begin
                    grp_next   = 2'd3;
                    state_next = (digits == '0) ? S_ZERO : S_HDIG;
                end
            end
            S_ZERO:
            begin
                if (load)
                begin
                    emit = 1'b1;
                    last = 1'b1;
                end
            end
            S_HDIG:
            begin
                if (load)
                begin
                    if (grp_zero)
                    begin
                        grp_next = grp_reg - 2'd1;
                    end
                    else if (hun != '0)
                    begin
                        emit       = 1'b1;
                        code       = {1'b0, hun};
                        state_next = S_HWORD;
                    end
                    else
                    begin
                        state_next = S_REST;
                    end
                end
            end
            S_HWORD:
            begin
                if (load)
                begin
                    emit       = 1'b1;
                    code       = ntw_pkg::WORD_HUNDRED;
                    last       = rest_zero && low_grp;
                    state_next = S_REST;
                end
            end
            S_REST:
            begin
                if (load)
                begin
                    state_next = S_SCALE;
                    if (!rest_zero)
                    begin
                        emit = 1'b1;
                        if (ten[3:1] == 3'd0)
                        begin
                            // One to nineteen is a single word.
                            code = ten[0] ? (ntw_pkg::WORD_TEEN_BASE + {1'b0, one})
                                          : {1'b0, one};
                            last = low_grp;
                        end
                        else
                        begin
                            code = ntw_pkg::WORD_TENS_BASE + {1'b0, ten};
                            last = (one == '0) && low_grp;
                            if (one != '0)
                            begin
                                state_next = S_ONES;
                            end
                        end
                    end
                end
            end
            S_ONES:
            begin
                if (load)
                begin
                    emit       = 1'b1;
                    code       = {1'b0, one};
                    last       = low_grp;
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (load)
                begin
                    if (low_grp)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        code       = ntw_pkg::WORD_SCALE_BASE + {3'b000, grp_reg};
                        last       = lower_zero;
                        grp_next   = grp_reg - 2'd1;
                        state_next = S_HDIG;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (emit && last)
        begin
            state_next = S_IDLE;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        last_next  = last_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            word_next  = code;
            last_next  = last;
        end
        else if (words.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            grp_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            grp_reg   <= grp_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        last_reg <= last_next;
    end

    assign idle            = (state_reg == S_IDLE);
    assign words.valid     = valid_reg;
    assign words.word_code = word_reg;
    assign words.last_word = last_reg;

`ifndef SYNTHESIS
    a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.busy || stat.done) |-> (state_reg == S_CONV))
        else $error("conversion active while the sequencer was not waiting");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last) |=> (state_reg == S_IDLE))
        else $error("sequencer kept running after the final word");

    a_zero_is_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ZERO && emit) |-> (last && code == ntw_pkg::WORD_ZERO))
        else $error("zero word emitted without the last flag");
`endif

endmodule

FILE: hdl/number_to_word_tokens.sv
// ----------------------------------------------------------------------------
// number_to_word_tokens: English name of an integer as word codes
// Accepts a 31-bit unsigned number and emits its English name, most
// significant group first, as a run of 5-bit word codes.
// ----------------------------------------------------------------------------
// The block takes one number at a time. On acceptance the number is turned
// into ten decimal digits by a shift-and-add-three converter that moves one
// bit per cycle. The word sequencer then walks the four base-1000 groups
// from billions down, one step per cycle while the output register can take
// a word: a hundreds digit and Hundred, a word for one to nineteen or a
// tens word and a ones word, and the scale word. Steps with nothing to say
// and all-zero groups give no word. A zero input gives the single word
// Zero. Input ready is high only while the sequencer is idle. Words leave
// through an output register that holds each word until the sink is ready,
// and the final word of each run carries last_word. Word codes are 0 Zero,
// 1 to 19 One to Nineteen, 20 to 27 Twenty to Ninety, 28 Hundred,
// 29 Thousand, 30 Million and 31 Billion.
// ----------------------------------------------------------------------------
module number_to_word_tokens (
    input  logic        clk,
    input  logic        rst_n,
    ntw_num_if.sink     num,
    ntw_word_if.source  words
);

    ntw_pkg::bcd_stat_t bcd_stat;
    ntw_pkg::bcd_t      digits;
    logic               idle;
    logic               accept;

    // A new number is taken only when the previous run has been handed
    // to the output register in full.
    assign num.ready = idle;
    assign accept    = num.valid && idle;

    // Binary to BCD unit.
    ntw_bcd u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .value  (num.number),
        .stat   (bcd_stat),
        .digits (digits)
    );

    // Group walker and output register.
    ntw_words u_words (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .stat   (bcd_stat),
        .digits (digits),
        .idle   (idle),
        .words  (words)
    );

endmodule
